// ===== src/mcqs_pkg.sv =====
package mcqs_pkg;

    localparam int unsigned DEF_MACHINES    = 8;
    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_STACK_DEPTH = 16;

    localparam int unsigned CFG_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned ID_W      = 4;
    localparam int unsigned LIM_W     = 5;
    localparam int unsigned ITEM_W    = 8;
    localparam int unsigned NRES_W    = 2;

    localparam logic [ID_W-1:0]  RST_MACHINE_COUNT = 4'd8;
    localparam logic [LIM_W-1:0] RST_LIMIT         = 5'd16;

    // result buffer
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PW    = 2;
    localparam int unsigned OQ_CW    = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ   = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_SERVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_QFULL = 2'd0,
        ERR_SFULL = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MACHINE_COUNT      = 2'd0,
        CFG_CLIENT_QUEUE_LIMIT = 2'd1,
        CFG_CLIENT_STACK_LIMIT = 2'd2,
        CFG_SERVER_QUEUE_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic tgt;
        logic srv;
        logic push;
        logic pop_s;
        logic enq;
        logic pop_q;
        logic app;
    } t_lane_op;

    typedef struct packed {
        logic [ID_W-1:0]   log_machine;
        logic              is_error;
        t_err              error_code;
        logic [ITEM_W-1:0] logged_item;
        logic              last;
    } t_result;

endpackage

// ===== src/mcqs_ram.sv =====
module mcqs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mcqs_lane.sv =====
module mcqs_lane #(
    parameter int unsigned QUEUE_DEPTH = mcqs_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned STACK_DEPTH = mcqs_pkg::DEF_STACK_DEPTH,
    parameter int unsigned QCW = $clog2(QUEUE_DEPTH + 1),
    parameter int unsigned SCW = $clog2(STACK_DEPTH + 1),
    parameter int unsigned QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcqs_pkg::t_lane_op   i_op,
    output logic [SCW-1:0]       o_scnt,
    output logic [QCW-1:0]       o_qcnt,
    output logic [QW-1:0]        o_qhead,
    output logic [QW-1:0]        o_qtail
);
    import mcqs_pkg::*;

    logic [SCW-1:0] r_scnt, n_scnt;
    logic [QCW-1:0] r_qcnt, n_qcnt;
    logic [QW-1:0]  r_qhead, n_qhead;
    logic [QW:0]    tail_sum;
    logic           q_inc, q_dec, s_inc, s_dec;

    always_comb begin
        q_inc = (i_op.tgt && i_op.enq) || (i_op.srv && i_op.app);
        q_dec = i_op.tgt && i_op.pop_q;
        s_inc = i_op.tgt && i_op.push;
        s_dec = i_op.tgt && i_op.pop_s;
    end

    always_comb begin
        n_qcnt = r_qcnt;
        if (q_inc && !q_dec) begin
            n_qcnt = r_qcnt + QCW'(1);
        end else if (q_dec && !q_inc) begin
            n_qcnt = r_qcnt - QCW'(1);
        end
        n_scnt = r_scnt;
        if (s_inc) begin
            n_scnt = r_scnt + SCW'(1);
        end else if (s_dec) begin
            n_scnt = r_scnt - SCW'(1);
        end
        n_qhead = r_qhead;
        if (q_dec) begin
            n_qhead = (r_qhead == QW'(QUEUE_DEPTH - 1)) ? '0 : r_qhead + QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt  <= '0;
            r_qcnt  <= '0;
            r_qhead <= '0;
        end else begin
            r_scnt  <= n_scnt;
            r_qcnt  <= n_qcnt;
            r_qhead <= n_qhead;
        end
    end

    // head plus count, wrapped once
    always_comb begin
        tail_sum = {1'b0, r_qhead} + (QW+1)'(r_qcnt);
        if (tail_sum >= (QW+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (QW+1)'(QUEUE_DEPTH);
        end
    end

    assign o_scnt  = r_scnt;
    assign o_qcnt  = r_qcnt;
    assign o_qhead = r_qhead;
    assign o_qtail = tail_sum[QW-1:0];

endmodule

// ===== src/mcqs_out_fifo.sv =====
module mcqs_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mcqs_pkg::NRES_W-1:0]   i_push_n,
    input  mcqs_pkg::t_result             i_e0,
    input  mcqs_pkg::t_result             i_e1,
    output logic                          o_room,
    output logic                          o_valid,
    input  logic                          i_stall,
    output mcqs_pkg::t_result             o_head
);
    import mcqs_pkg::*;

    t_result            r_mem [OQ_DEPTH];
    logic [OQ_PW-1:0]   r_wp, r_rp;
    logic [OQ_CW-1:0]   r_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OQ_PW'(i_push_n);
            r_rp  <= r_rp + OQ_PW'(pop);
            r_cnt <= r_cnt + OQ_CW'(i_push_n) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != '0) begin
            r_mem[r_wp] <= i_e0;
        end
        if (i_push_n == NRES_W'(2)) begin
            r_mem[r_wp + OQ_PW'(1)] <= i_e1;
        end
    end

endmodule

// ===== src/multi_client_queue_stack_server.sv =====
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------------------
// command   | i_in_valid   | o_in_stall   | i_command, i_client, i_item
// log       | o_out_valid  | i_out_stall  | o_log_machine, o_is_error, o_error_code,
//           |              |              | o_logged_item, o_last
// config    | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// one command per cycle enters while the result buffer holds two or fewer entries
// a command reaches the result buffer through the input register,
// then the result stage with the memory read; log entries leave one per cycle unless stalled
// a taken item sent to a full server queue gives two entries; the log port sets the rate
// reset clears all counts and loads the register defaults; the stores are not cleared
// o_in_stall rises only from result buffer occupancy, never from i_in_valid
module multi_client_queue_stack_server #(
    parameter int unsigned MACHINES    = mcqs_pkg::DEF_MACHINES,
    parameter int unsigned QUEUE_DEPTH = mcqs_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned STACK_DEPTH = mcqs_pkg::DEF_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcqs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcqs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mcqs_pkg::CMD_W-1:0]     i_command,
    input  logic [mcqs_pkg::ID_W-1:0]      i_client,
    input  logic [mcqs_pkg::ITEM_W-1:0]    i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mcqs_pkg::ID_W-1:0]      o_log_machine,
    output logic                           o_is_error,
    output logic [1:0]                     o_error_code,
    output logic [mcqs_pkg::ITEM_W-1:0]    o_logged_item,
    output logic                           o_last
);
    import mcqs_pkg::*;

    localparam int unsigned MW   = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int unsigned QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SCW  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned QLW  = (QCW > LIM_W) ? QCW : LIM_W;
    localparam int unsigned SLW  = (SCW > LIM_W) ? SCW : LIM_W;
    localparam int unsigned QAW  = MW + QW;
    localparam int unsigned SAW  = MW + SW;
    localparam int unsigned QRAM_DEPTH = 1 << QAW;
    localparam int unsigned SRAM_DEPTH = 1 << SAW;
    localparam logic [ID_W-1:0] MC_CAP = ID_W'((MACHINES < 15) ? MACHINES : 15);

    // configuration
    logic [ID_W-1:0]  r_mc;
    logic [LIM_W-1:0] r_cq_lim, r_cs_lim, r_sq_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc     <= RST_MACHINE_COUNT;
            r_cq_lim <= RST_LIMIT;
            r_cs_lim <= RST_LIMIT;
            r_sq_lim <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MACHINE_COUNT:      r_mc     <= i_cfg_data[ID_W-1:0];
                CFG_CLIENT_QUEUE_LIMIT: r_cq_lim <= i_cfg_data[LIM_W-1:0];
                CFG_CLIENT_STACK_LIMIT: r_cs_lim <= i_cfg_data[LIM_W-1:0];
                CFG_SERVER_QUEUE_LIMIT: r_sq_lim <= i_cfg_data[LIM_W-1:0];
                default:                r_mc     <= r_mc;
            endcase
        end
    end

    logic go;
    t_result fifo_head;

    // input register
    logic              r_b_valid;
    t_cmd              r_b_cmd;
    logic [ID_W-1:0]   r_b_client;
    logic [ITEM_W-1:0] r_b_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (go) begin
            r_b_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_cmd    <= t_cmd'(i_command);
            r_b_client <= i_client;
            r_b_item   <= i_item;
        end
    end

    // decode
    logic [ID_W-1:0] n_eff, srv4, tgt4;
    logic [MW-1:0]   tgt_idx, srv_idx;
    logic            id_ok, is_serve, ok, tgt_is_srv;

    always_comb begin
        if (r_mc == '0) begin
            n_eff = ID_W'(1);
        end else if (r_mc > MC_CAP) begin
            n_eff = MC_CAP;
        end else begin
            n_eff = r_mc;
        end
        srv4       = n_eff - ID_W'(1);
        is_serve   = (r_b_cmd == CMD_SERVE);
        id_ok      = (r_b_client != '0) && (r_b_client <= n_eff);
        tgt4       = is_serve ? srv4 : r_b_client - ID_W'(1);
        tgt_idx    = MW'(tgt4);
        srv_idx    = MW'(srv4);
        tgt_is_srv = (tgt4 == srv4);
        ok         = r_b_valid && go && (is_serve || id_ok);
    end

    // per-machine counters
    logic [SCW-1:0] l_scnt  [MACHINES];
    logic [QCW-1:0] l_qcnt  [MACHINES];
    logic [QW-1:0]  l_qhead [MACHINES];
    logic [QW-1:0]  l_qtail [MACHINES];
    t_lane_op       lane_op [MACHINES];

    logic [SCW-1:0] t_scnt;
    logic [QCW-1:0] t_qcnt, s_qcnt, s_after;
    logic [QW-1:0]  t_qhead, t_qtail, s_qtail;

    always_comb begin
        t_scnt  = '0;
        t_qcnt  = '0;
        t_qhead = '0;
        t_qtail = '0;
        s_qcnt  = '0;
        s_qtail = '0;
        for (int i = 0; i < MACHINES; i++) begin
            if (tgt_idx == MW'(i)) begin
                t_scnt  = t_scnt  | l_scnt[i];
                t_qcnt  = t_qcnt  | l_qcnt[i];
                t_qhead = t_qhead | l_qhead[i];
                t_qtail = t_qtail | l_qtail[i];
            end
            if (srv_idx == MW'(i)) begin
                s_qcnt  = s_qcnt  | l_qcnt[i];
                s_qtail = s_qtail | l_qtail[i];
            end
        end
    end

    logic [LIM_W-1:0] lim_t;
    logic q_full_t, s_full_t, full_srv;
    logic pop_s_raw, pop_q_raw, took_raw;
    logic do_enq, do_push, pop_s, pop_q, empty, app, app_err, is_send;

    always_comb begin
        lim_t     = tgt_is_srv ? r_sq_lim : r_cq_lim;
        q_full_t  = (t_qcnt >= QCW'(QUEUE_DEPTH)) || (QLW'(t_qcnt) >= QLW'(lim_t));
        s_full_t  = (t_scnt >= SCW'(STACK_DEPTH)) || (SLW'(t_scnt) >= SLW'(r_cs_lim));
        pop_s_raw = (t_scnt != '0);
        pop_q_raw = (t_scnt == '0) && (t_qcnt != '0);
        took_raw  = pop_s_raw || pop_q_raw;
        s_after   = (tgt_is_srv && pop_q_raw) ? s_qcnt - QCW'(1) : s_qcnt;
        full_srv  = (s_after >= QCW'(QUEUE_DEPTH)) || (QLW'(s_after) >= QLW'(r_sq_lim));
        is_send   = (r_b_cmd == CMD_SEND);
        do_enq    = ok && (r_b_cmd == CMD_ENQ) && !q_full_t;
        do_push   = ok && (r_b_cmd == CMD_PUSH) && !s_full_t;
        pop_s     = ok && (is_send || is_serve) && pop_s_raw;
        pop_q     = ok && (is_send || is_serve) && pop_q_raw;
        empty     = ok && (is_send || is_serve) && !took_raw;
        app       = ok && is_send && took_raw && !full_srv;
        app_err   = ok && is_send && took_raw && full_srv;
    end

    for (genvar g = 0; g < MACHINES; g++) begin : g_lane
        always_comb begin
            lane_op[g].tgt   = (tgt_idx == MW'(g));
            lane_op[g].srv   = (srv_idx == MW'(g));
            lane_op[g].push  = do_push;
            lane_op[g].pop_s = pop_s;
            lane_op[g].enq   = do_enq;
            lane_op[g].pop_q = pop_q;
            lane_op[g].app   = app;
        end

        mcqs_lane #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .STACK_DEPTH (STACK_DEPTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (lane_op[g]),
            .o_scnt  (l_scnt[g]),
            .o_qcnt  (l_qcnt[g]),
            .o_qhead (l_qhead[g]),
            .o_qtail (l_qtail[g])
        );
    end

    // result stage registers
    logic [NRES_W-1:0] r_c_nres, n_nres;
    logic [ID_W-1:0]   r_c_m0, r_c_srv_log;
    logic              r_c_err0, r_c_from_s, r_c_fwd, r_c_use_got;
    t_err              r_c_code0, n_code0;
    logic [ITEM_W-1:0] r_c_fwd_data, r_c_item;
    logic              r_c_we_q, r_c_we_s;
    logic [QAW-1:0]    r_c_waddr_q, n_waddr_q, raddr_q;
    logic [SAW-1:0]    r_c_waddr_s, n_waddr_s, raddr_s;
    logic [ITEM_W-1:0] rd_q, rd_s, got, c_wdata_q;
    logic              n_fwd;

    always_comb begin
        n_nres  = '0;
        n_code0 = ERR_EMPTY;
        if (ok) begin
            unique case (r_b_cmd)
                CMD_ENQ: begin
                    n_nres  = q_full_t ? NRES_W'(1) : '0;
                    n_code0 = ERR_QFULL;
                end
                CMD_PUSH: begin
                    n_nres  = s_full_t ? NRES_W'(1) : '0;
                    n_code0 = ERR_SFULL;
                end
                CMD_SEND, CMD_SERVE: begin
                    n_nres  = app_err ? NRES_W'(2) : NRES_W'(1);
                    n_code0 = ERR_EMPTY;
                end
                default: n_nres = '0;
            endcase
        end
        n_waddr_q = do_enq ? {tgt_idx, t_qtail} : {srv_idx, s_qtail};
        n_waddr_s = {tgt_idx, SW'(t_scnt)};
        raddr_q   = {tgt_idx, t_qhead};
        raddr_s   = {tgt_idx, SW'(t_scnt - SCW'(1))};
        // a write still pending in the result stage must reach this read
        n_fwd     = (pop_s && r_c_we_s && (r_c_waddr_s == raddr_s))
                 || (pop_q && r_c_we_q && (r_c_waddr_q == raddr_q));
    end

    always_comb begin
        if (r_c_fwd) begin
            got = r_c_fwd_data;
        end else begin
            got = r_c_from_s ? rd_s : rd_q;
        end
        c_wdata_q = r_c_use_got ? got : r_c_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_nres <= '0;
            r_c_we_q <= 1'b0;
            r_c_we_s <= 1'b0;
        end else if (go) begin
            r_c_nres <= n_nres;
            r_c_we_q <= do_enq || app;
            r_c_we_s <= do_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_c_m0       <= tgt4 + ID_W'(1);
            r_c_srv_log  <= n_eff;
            r_c_err0     <= empty || !(pop_s || pop_q);
            r_c_code0    <= n_code0;
            r_c_from_s   <= pop_s;
            r_c_fwd      <= n_fwd;
            r_c_fwd_data <= pop_s ? r_c_item : c_wdata_q;
            r_c_use_got  <= app;
            r_c_waddr_q  <= n_waddr_q;
            r_c_waddr_s  <= n_waddr_s;
            r_c_item     <= r_b_item;
        end
    end

    mcqs_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (QRAM_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (r_c_we_q && go),
        .i_waddr (r_c_waddr_q),
        .i_wdata (c_wdata_q),
        .i_re    (pop_q),
        .i_raddr (raddr_q),
        .o_rdata (rd_q)
    );

    mcqs_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (SRAM_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (r_c_we_s && go),
        .i_waddr (r_c_waddr_s),
        .i_wdata (r_c_item),
        .i_re    (pop_s),
        .i_raddr (raddr_s),
        .o_rdata (rd_s)
    );

    // result entries
    t_result e0, e1;
    logic [NRES_W-1:0] push_n;

    always_comb begin
        e0.log_machine = r_c_m0;
        e0.is_error    = r_c_err0;
        e0.error_code  = r_c_err0 ? r_c_code0 : ERR_QFULL;
        e0.logged_item = r_c_err0 ? '0 : got;
        e0.last        = (r_c_nres == NRES_W'(1));
        e1.log_machine = r_c_srv_log;
        e1.is_error    = 1'b1;
        e1.error_code  = ERR_QFULL;
        e1.logged_item = '0;
        e1.last        = 1'b1;
        push_n         = go ? r_c_nres : '0;
    end

    mcqs_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_e0     (e0),
        .i_e1     (e1),
        .o_room   (go),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_head   (fifo_head)
    );

    assign o_in_stall    = !go;
    assign o_log_machine = fifo_head.log_machine;
    assign o_is_error    = fifo_head.is_error;
    assign o_error_code  = fifo_head.error_code;
    assign o_logged_item = fifo_head.logged_item;
    assign o_last        = fifo_head.last;

`ifndef SYNTHESIS
    a_one_queue_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_enq && app))
        else $error("enqueue and server append in one cycle");

    a_take_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({pop_s, pop_q, empty}))
        else $error("take resolved more than one way");

    a_two_results_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_nres == NRES_W'(2)) |-> (!r_c_err0 && !r_c_we_q))
        else $error("second entry without a logged item or with an append");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> ((t_qcnt <= QCW'(QUEUE_DEPTH)) && (t_scnt <= SCW'(STACK_DEPTH))))
        else $error("machine count beyond depth");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !go |=> ($stable(r_b_valid) && $stable(r_c_nres) && $stable(r_c_we_q)))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== bench/mcqs_log_checker.sv =====
module mcqs_log_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcqs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcqs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [mcqs_pkg::CMD_W-1:0]     i_command,
    input  logic [mcqs_pkg::ID_W-1:0]      i_client,
    input  logic [mcqs_pkg::ITEM_W-1:0]    i_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [mcqs_pkg::ID_W-1:0]      i_log_machine,
    input  logic                           i_is_error,
    input  logic [1:0]                     i_error_code,
    input  logic [mcqs_pkg::ITEM_W-1:0]    i_logged_item,
    input  logic                           i_last,
    output int                             o_failures,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcqs_pkg::*;

    logic [ID_W-1:0]   machines_cfg;
    logic [LIM_W-1:0]  client_fifo_lim;
    logic [LIM_W-1:0]  lifo_lim;
    logic [LIM_W-1:0]  server_fifo_lim;

    logic [ITEM_W-1:0] fifo_mem [DEF_MACHINES][DEF_QUEUE_DEPTH];
    int unsigned       fifo_cnt [DEF_MACHINES];
    logic [ITEM_W-1:0] lifo_mem [DEF_MACHINES][DEF_STACK_DEPTH];
    int unsigned       lifo_cnt [DEF_MACHINES];

    t_result log_expected [$];
    t_result want;
    int      failures = 0;

    // stack top first, queue head otherwise
    function automatic bit take_item_from(input int unsigned m, output logic [ITEM_W-1:0] v);
        v = '0;
        if (lifo_cnt[m] > 0) begin
            lifo_cnt[m]--;
            v = lifo_mem[m][lifo_cnt[m]];
            return 1'b1;
        end
        if (fifo_cnt[m] > 0) begin
            v = fifo_mem[m][0];
            for (int i = 0; i + 1 < fifo_cnt[m]; i++)
                fifo_mem[m][i] = fifo_mem[m][i + 1];
            fifo_cnt[m]--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit append_to_fifo(input int unsigned m, input int unsigned srv,
                                          input logic [ITEM_W-1:0] v);
        int unsigned cap;
        cap = (m == srv) ? server_fifo_lim : client_fifo_lim;
        if (cap > DEF_QUEUE_DEPTH)
            cap = DEF_QUEUE_DEPTH;
        if (fifo_cnt[m] >= cap)
            return 1'b0;
        fifo_mem[m][fifo_cnt[m]] = v;
        fifo_cnt[m]++;
        return 1'b1;
    endfunction

    function automatic t_result log_entry(input int unsigned m, input logic err,
                                          input t_err code, input logic [ITEM_W-1:0] v);
        t_result r;
        r.log_machine = ID_W'(m + 1);
        r.is_error    = err;
        r.error_code  = err ? code : ERR_QFULL;
        r.logged_item = err ? '0 : v;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic void predict_log_entries(input t_cmd cmd, input logic [ID_W-1:0] id,
                                                input logic [ITEM_W-1:0] v);
        t_result           entries [$];
        int unsigned       in_use;
        int unsigned       srv;
        int unsigned       m;
        int unsigned       lifo_cap;
        logic [ITEM_W-1:0] got;
        in_use = machines_cfg;
        if (in_use < 1)
            in_use = 1;
        if (in_use > DEF_MACHINES)
            in_use = DEF_MACHINES;
        srv = in_use - 1;
        lifo_cap = (lifo_lim > DEF_STACK_DEPTH) ? DEF_STACK_DEPTH : lifo_lim;
        m = (id == 0) ? 0 : id - 1;
        if (cmd == CMD_SERVE) begin
            if (take_item_from(srv, got))
                entries.push_back(log_entry(srv, 1'b0, ERR_QFULL, got));
            else
                entries.push_back(log_entry(srv, 1'b1, ERR_EMPTY, '0));
        end else if (id >= 1 && id <= in_use) begin
            case (cmd)
                CMD_ENQ: begin
                    if (!append_to_fifo(m, srv, v))
                        entries.push_back(log_entry(m, 1'b1, ERR_QFULL, '0));
                end
                CMD_PUSH: begin
                    if (lifo_cnt[m] >= lifo_cap) begin
                        entries.push_back(log_entry(m, 1'b1, ERR_SFULL, '0));
                    end else begin
                        lifo_mem[m][lifo_cnt[m]] = v;
                        lifo_cnt[m]++;
                    end
                end
                default: begin
                    if (!take_item_from(m, got)) begin
                        entries.push_back(log_entry(m, 1'b1, ERR_EMPTY, '0));
                    end else begin
                        entries.push_back(log_entry(m, 1'b0, ERR_QFULL, got));
                        if (!append_to_fifo(srv, srv, got))
                            entries.push_back(log_entry(srv, 1'b1, ERR_QFULL, '0));
                    end
                end
            endcase
        end
        if (entries.size() > 0)
            entries[entries.size() - 1].last = 1'b1;
        foreach (entries[i])
            log_expected.push_back(entries[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            machines_cfg    = RST_MACHINE_COUNT;
            client_fifo_lim = RST_LIMIT;
            lifo_lim        = RST_LIMIT;
            server_fifo_lim = RST_LIMIT;
            foreach (fifo_cnt[i])
                fifo_cnt[i] = 0;
            foreach (lifo_cnt[i])
                lifo_cnt[i] = 0;
            log_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MACHINE_COUNT:      machines_cfg    = i_cfg_data[ID_W-1:0];
                    CFG_CLIENT_QUEUE_LIMIT: client_fifo_lim = i_cfg_data;
                    CFG_CLIENT_STACK_LIMIT: lifo_lim        = i_cfg_data;
                    CFG_SERVER_QUEUE_LIMIT: server_fifo_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_log_entries(t_cmd'(i_command), i_client, i_item);
            if (i_out_valid && !i_out_stall) begin
                if (log_expected.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: log entry with nothing pending: machine %0d err %0b",
                                 $realtime, i_log_machine, i_is_error);
                end else begin
                    want = log_expected.pop_front();
                    if (i_log_machine !== want.log_machine || i_is_error !== want.is_error
                            || i_error_code !== want.error_code
                            || i_logged_item !== want.logged_item || i_last !== want.last) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: log mismatch, expected m%0d e%0b c%0d i%02h l%0b",
                                     $realtime, want.log_machine, want.is_error,
                                     want.error_code, want.logged_item, want.last);
                            $display("%0t:                  actual   m%0d e%0b c%0d i%02h l%0b",
                                     $realtime, i_log_machine, i_is_error, i_error_code,
                                     i_logged_item, i_last);
                        end
                    end
                end
            end
        end
        o_pending  <= log_expected.size();
        o_failures <= failures;
    end

endmodule

// ===== bench/multi_client_queue_stack_server_test.sv =====
module multi_client_queue_stack_server_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mcqs_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      client;
    logic [ITEM_W-1:0]    item;
    logic                 out_valid;
    logic                 out_stall;
    logic [ID_W-1:0]      log_machine;
    logic                 is_error;
    logic [1:0]           error_code;
    logic [ITEM_W-1:0]    logged_item;
    logic                 log_last;

    int   failures;
    int   pending;
    logic no_idle;
    logic hold_req;

    logic [CFG_W-1:0] plan [6][4] = '{
        '{5'd8,  5'd16, 5'd16, 5'd16},
        '{5'd1,  5'd1,  5'd1,  5'd1},
        '{5'd0,  5'd0,  5'd0,  5'd0},
        '{5'd15, 5'd31, 5'd31, 5'd31},
        '{5'd4,  5'd3,  5'd2,  5'd5},
        '{5'd2,  5'd16, 5'd1,  5'd1}
    };
    int plan_items [6] = '{200, 100, 60, 150, 150, 100};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_client_queue_stack_server dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_client      (client),
        .i_item        (item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_log_machine (log_machine),
        .o_is_error    (is_error),
        .o_error_code  (error_code),
        .o_logged_item (logged_item),
        .o_last        (log_last)
    );

    mcqs_log_checker log_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_client      (client),
        .i_item        (item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_log_machine (log_machine),
        .i_is_error    (is_error),
        .i_error_code  (error_code),
        .i_logged_item (logged_item),
        .i_last        (log_last),
        .o_failures    (failures),
        .o_pending     (pending)
    );

    // log receiver: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end else begin
                out_stall <= !no_idle && ($urandom_range(99) < 9);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic issue(input t_cmd cmd, input logic [ID_W-1:0] id,
                         input logic [ITEM_W-1:0] v);
        while (!no_idle && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        client   <= id;
        item     <= v;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // only once every transaction has drained and the pipeline is empty
    task automatic configure(input logic [CFG_W-1:0] mc, input logic [CFG_W-1:0] cql,
                             input logic [CFG_W-1:0] csl, input logic [CFG_W-1:0] sql);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        write_reg(CFG_MACHINE_COUNT, mc);
        write_reg(CFG_CLIENT_QUEUE_LIMIT, cql);
        write_reg(CFG_CLIENT_STACK_LIMIT, csl);
        write_reg(CFG_SERVER_QUEUE_LIMIT, sql);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int count, input logic [CFG_W-1:0] mc);
        int unsigned     in_use;
        int unsigned     pick;
        t_cmd            cmd;
        logic [ID_W-1:0] id;
        in_use = (mc[3:0] == 0) ? 1 : ((mc[3:0] > DEF_MACHINES) ? DEF_MACHINES : mc[3:0]);
        repeat (count) begin
            pick = $urandom_range(99);
            cmd = (pick < 30) ? CMD_ENQ : (pick < 55) ? CMD_PUSH :
                  (pick < 85) ? CMD_SEND : CMD_SERVE;
            if ($urandom_range(99) < 85)
                id = ID_W'($urandom_range(in_use, 1));
            else
                id = ID_W'($urandom_range(15));
            issue(cmd, id, ITEM_W'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] mc;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MACHINE_COUNT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        command   <= CMD_ENQ;
        client    <= '0;
        item      <= '0;
        no_idle   <= 1'b0;
        hold_req  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three machines, every store holds one byte
        configure(5'd3, 5'd1, 5'd1, 5'd1);
        issue(CMD_ENQ, 4'd1, 8'h00);
        issue(CMD_ENQ, 4'd1, 8'hFF);
        issue(CMD_PUSH, 4'd1, 8'hA5);
        issue(CMD_PUSH, 4'd1, 8'h5A);
        issue(CMD_SEND, 4'd1, 8'h00);
        // server queue already full: item is lost
        issue(CMD_SEND, 4'd1, 8'hFF);
        issue(CMD_SEND, 4'd1, 8'h00);
        issue(CMD_SERVE, 4'd0, 8'h00);
        issue(CMD_SERVE, 4'd15, 8'hFF);
        issue(CMD_SEND, 4'd3, 8'h00);
        issue(CMD_PUSH, 4'd3, 8'h11);
        // server sends to itself
        issue(CMD_SEND, 4'd3, 8'h00);
        issue(CMD_SERVE, 4'd8, 8'h00);
        // ids outside the machines in use
        issue(CMD_ENQ, 4'd0, 8'h3C);
        issue(CMD_PUSH, 4'd4, 8'hC3);
        issue(CMD_SEND, 4'd15, 8'h00);
        issue(CMD_ENQ, 4'd2, 8'h81);
        issue(CMD_PUSH, 4'd2, 8'h7E);
        issue(CMD_SEND, 4'd2, 8'h00);
        issue(CMD_SEND, 4'd2, 8'h00);
        issue(CMD_SEND, 4'd3, 8'h00);
        issue(CMD_SERVE, 4'd5, 8'h00);

        for (int p = 0; p < 6; p++) begin
            configure(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
            hold_req <= (p == 0);
            no_idle  <= (p == 3);
            run_random(plan_items[p], plan[p][0]);
        end
        no_idle  <= 1'b0;
        hold_req <= 1'b0;
        repeat (3) begin
            mc = CFG_W'($urandom_range(31));
            configure(mc, CFG_W'($urandom_range(31)), CFG_W'($urandom_range(31)),
                      CFG_W'($urandom_range(31)));
            run_random(80, mc);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== multi_client_queue_stack_server.f =====
src/mcqs_pkg.sv
src/mcqs_ram.sv
src/mcqs_lane.sv
src/mcqs_out_fifo.sv
src/multi_client_queue_stack_server.sv
bench/mcqs_log_checker.sv
bench/multi_client_queue_stack_server_test.sv
